FILE: hw/rtl/firdf_pkg.sv
`default_nettype none

package firdf_pkg;

   // Filter size and field widths
   localparam int TAPS   = 64;
   localparam int PTR_W  = $clog2(TAPS);
   localparam int SAMP_W = 16;
   localparam int COEF_W = 18;
   localparam int IDX_W  = 6;
   localparam int OUT_W  = 40;
   localparam int PROD_W = SAMP_W + COEF_W;
   localparam int SUM_W  = PROD_W + PTR_W + 1;
   localparam int ACC_W  = (SUM_W > OUT_W) ? SUM_W : OUT_W;

   // Item kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_COEF   = 1'b1;

   typedef logic                     kind_type;
   typedef logic signed [SAMP_W-1:0] sample_type;
   typedef logic [IDX_W-1:0]         index_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [OUT_W-1:0]  out_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic [PTR_W-1:0]         ptr_type;

   // Controller to datapath commands
   typedef struct packed {
      logic coef_wr;   // store one coefficient
      logic start;     // store sample, load read pointers, clear accumulator
      logic issue;     // issue one tap read
      logic load_out;  // move the saturated sum into the output register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic last_tap;   // the tap being issued is the final one
      logic pipe_busy;  // reads or products still in flight
   } stat_type;

   // Clamp the accumulator to the output width
   function automatic out_type sat_out(acc_type acc);
      logic [ACC_W-OUT_W:0] upper;
      out_type              res;
      upper = acc[ACC_W-1:OUT_W-1];
      if ((&upper) || !(|upper)) begin
         res = acc[OUT_W-1:0];
      end else if (acc[ACC_W-1]) begin
         res = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(OUT_W-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/firdf_datapath.sv
`default_nettype none

module firdf_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire firdf_pkg::cmd_type    cmd,
   input  wire firdf_pkg::sample_type req_sample_in,
   input  wire firdf_pkg::index_type  req_coef_index,
   input  wire firdf_pkg::coef_type   req_coef_value,
   output firdf_pkg::stat_type        stat,
   output firdf_pkg::out_type         rsp_filtered
);
   import firdf_pkg::*;

   // Sample ring and coefficient memories
   sample_type samp_mem [TAPS];
   coef_type   coef_mem [TAPS];
   logic [TAPS-1:0] samp_vld_ff, samp_vld_in;
   logic [TAPS-1:0] coef_vld_ff, coef_vld_in;

   ptr_type wp_ff, wp_in;
   ptr_type rd_ptr_ff, rd_ptr_in;
   ptr_type tap_ff, tap_in;

   sample_type samp_rd_ff;
   coef_type   coef_rd_ff;
   logic       samp_ok_ff, coef_ok_ff;
   logic       vld1_ff, vld2_ff;
   prod_type   prod_ff, prod_in;
   acc_type    acc_ff, acc_in;
   out_type    out_ff;

   logic    coef_hit;
   ptr_type coef_addr;
   sample_type samp_op;
   coef_type   coef_op;

   assign coef_hit  = int'(req_coef_index) < TAPS;
   assign coef_addr = PTR_W'(req_coef_index);

   // Memory writes
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         samp_mem[wp_ff] <= req_sample_in;
      end
      if (cmd.coef_wr && coef_hit) begin
         coef_mem[coef_addr] <= req_coef_value;
      end
   end

   // Registered memory reads
   always_ff @(posedge clock) begin
      samp_rd_ff <= samp_mem[rd_ptr_ff];
      coef_rd_ff <= coef_mem[tap_ff];
      samp_ok_ff <= samp_vld_ff[rd_ptr_ff];
      coef_ok_ff <= coef_vld_ff[tap_ff];
   end

   // Entry valid bits: unwritten entries read as zero
   always_comb begin
      samp_vld_in = samp_vld_ff;
      coef_vld_in = coef_vld_ff;
      if (cmd.start) begin
         samp_vld_in[wp_ff] = 1'b1;
      end
      if (cmd.coef_wr && coef_hit) begin
         coef_vld_in[coef_addr] = 1'b1;
      end
   end

   // Pointers: write pointer wraps up, read pointer walks back in time
   always_comb begin
      wp_in     = wp_ff;
      rd_ptr_in = rd_ptr_ff;
      tap_in    = tap_ff;
      if (cmd.start) begin
         wp_in     = (wp_ff == PTR_W'(TAPS-1)) ? '0 : wp_ff + 1'b1;
         rd_ptr_in = wp_ff;
         tap_in    = '0;
      end else if (cmd.issue) begin
         rd_ptr_in = (rd_ptr_ff == '0) ? PTR_W'(TAPS-1) : rd_ptr_ff - 1'b1;
         tap_in    = tap_ff + 1'b1;
      end
   end

   // Multiply stage
   assign samp_op = samp_ok_ff ? samp_rd_ff : '0;
   assign coef_op = coef_ok_ff ? coef_rd_ff : '0;
   assign prod_in = PROD_W'(samp_op) * PROD_W'(coef_op);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Accumulate stage
   always_comb begin
      acc_in = acc_ff;
      if (cmd.start) begin
         acc_in = '0;
      end else if (vld2_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         samp_vld_ff <= '0;
         coef_vld_ff <= '0;
         wp_ff       <= '0;
         vld1_ff     <= 1'b0;
         vld2_ff     <= 1'b0;
      end else begin
         samp_vld_ff <= samp_vld_in;
         coef_vld_ff <= coef_vld_in;
         wp_ff       <= wp_in;
         vld1_ff     <= cmd.issue;
         vld2_ff     <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      tap_ff    <= tap_in;
      acc_ff    <= acc_in;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_ff <= sat_out(acc_ff);
      end
   end

   assign rsp_filtered   = out_ff;
   assign stat.last_tap  = (tap_ff == PTR_W'(TAPS-1));
   assign stat.pipe_busy = vld1_ff || vld2_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/firdf_ctrl.sv
`default_nettype none

module firdf_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire firdf_pkg::kind_type req_kind,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   input  wire firdf_pkg::stat_type stat,
   output firdf_pkg::cmd_type       cmd
);
   import firdf_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_xfer;
   logic       out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Sequencer: accept, walk the taps, drain the pipe, hand over the sum
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_kind == KIND_COEF) begin
                  cmd.coef_wr = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            if (stat.last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid: cleared on transfer, set on load
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/fir_filter_direct_form.sv
// Channel   Direction  Ports
// req       in         req_valid, req_stall, req_kind, req_sample_in,
//                      req_coef_index, req_coef_value
// rsp       out        rsp_valid, rsp_stall, rsp_filtered
//
// A coefficient item is stored without leaving idle. For a sample item
// one shared multiply-accumulate walks the taps, one read of
// each memory per cycle, then the pipe drains and the output is loaded.
// Synchronous active-high reset empties both memories (entry valid bits) and
// zeroes the write pointer. The finished sum waits in an output register;
// a stalled result holds the next one back only at its load.
`default_nettype none

module fir_filter_direct_form (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire firdf_pkg::kind_type   req_kind,
   input  wire firdf_pkg::sample_type req_sample_in,
   input  wire firdf_pkg::index_type  req_coef_index,
   input  wire firdf_pkg::coef_type   req_coef_value,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output firdf_pkg::out_type         rsp_filtered
);
   import firdf_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   firdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   firdf_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_sample_in  (req_sample_in),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .stat           (stat),
      .rsp_filtered   (rsp_filtered)
   );

`ifndef SYNTHESIS
   // A sample transfer makes the block busy on the next cycle
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_kind == KIND_SAMPLE) |=> req_stall)
      else $error("input not stalled after sample transfer");

   // A coefficient write never produces a result
   a_coef_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_kind == KIND_COEF) |=> !$rose(rsp_valid))
      else $error("result raised after coefficient write");

   // A new result only appears at the end of a filtering pass
   a_result_from_pass: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result raised while block idle");

   // The block is still busy as the last tap of the walk is issued
   a_walk_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_kind == KIND_SAMPLE) |-> ##TAPS req_stall)
      else $error("input accepted during tap walk");
`endif

endmodule

`default_nettype wire
